>>> rtl/core/avwd_pkg.sv
// avwd_pkg: shared types, constants and tables of the variable-width adpcm decoder
// no dependencies; imported by adpcm_variable_width_decoder_unit

package avwd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int HDR_IDX_W  = 6;
  localparam int CODE_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int STEP_IDX_W = 7;
  localparam int STEP_W     = 15;
  localparam int MOVE_W     = 6;
  localparam int MOVE_AT_W  = 5;

  localparam logic [STEP_IDX_W-1:0] MAX_STEP_IDX = 7'd88;

  // tuser bit 0
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_CODE   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO    = 1'd1;

  localparam logic [2:0] CODE_BITS_RESET = 3'd4;

  typedef logic [STEP_W-1:0] step_t;
  typedef logic signed [MOVE_W-1:0] move_t;

  localparam step_t STEP_TABLE [0:88] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  // index moves for widths 2, 3, 4, 5 laid end to end
  localparam move_t INDEX_MOVE [0:29] = '{
    -6'sd1, 6'sd2,
    -6'sd1, -6'sd1, 6'sd2, 6'sd4,
    -6'sd1, -6'sd1, -6'sd1, -6'sd1, 6'sd2, 6'sd4, 6'sd6, 6'sd8,
    -6'sd1, -6'sd1, -6'sd1, -6'sd1, -6'sd1, -6'sd1, -6'sd1, -6'sd1,
    6'sd1, 6'sd2, 6'sd4, 6'sd6, 6'sd8, 6'sd10, 6'sd13, 6'sd16
  };

endpackage

>>> rtl/core/adpcm_variable_width_decoder_unit.sv
// adpcm_variable_width_decoder_unit: top level of the variable-width adpcm decoder
// depends on avwd_pkg for tables, widths and codes

// Decodes IMA-style ADPCM with 2 to 5 bit codes for one or two channels. Each
// request is a block header (loads the channel's predictor and step index and
// returns the predictor) or a delta code (returns the updated predictor), and
// gives exactly one sample. One request is taken every clock cycle unless
// back-pressure holds it; a sample passes the input register, step table
// lookup, shift-add and saturation into the output register. Back-pressure on
// the output stalls the input only once both registers hold. The user must
// write code_bits and stereo on the cfg channel only while no request is in
// flight (not enforced); code_bits outside 2..5 acts as the nearest bound.
module adpcm_variable_width_decoder_unit #(
  parameter int MAX_CHANNELS = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] header_predictor, [21:16] header_index, [26:22] code, [31:27] zero
  input  logic [avwd_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] kind, [1] channel
  input  logic [avwd_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] sample
  output logic [avwd_pkg::SAMPLE_W-1:0]     out_tdata,
  // [0] sample_channel
  output logic                              out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [avwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [avwd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import avwd_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [2:0] code_bits_r;
  logic       stereo_r;

  logic                        in_valid_r;
  logic                        in_kind_r;
  logic                        in_ch_r;
  logic signed [SAMPLE_W-1:0]  in_hp_r;
  logic [HDR_IDX_W-1:0]        in_hi_r;
  logic [CODE_W-1:0]           in_code_r;
  logic                        in_last_r;

  logic signed [SAMPLE_W-1:0]  pred_r [MAX_CHANNELS];
  logic [STEP_IDX_W-1:0]       step_idx_r [MAX_CHANNELS];

  logic                        out_valid_r;
  logic [SAMPLE_W-1:0]         out_data_r;
  logic                        out_ch_r;
  logic                        out_last_r;

  logic                        advance;
  logic                        in_acc;
  logic                        ch_eff;
  logic [CH_W-1:0]             ch_idx;
  logic [2:0]                  width;
  logic [CODE_W-1:0]           mag;
  logic                        sign;
  logic [3:0]                  mag_al;
  logic [MOVE_AT_W-1:0]        move_base;
  logic [MOVE_AT_W-1:0]        move_at;
  logic [STEP_IDX_W-1:0]       si;
  step_t                       step;
  step_t                       tail;
  logic [STEP_W+1:0]           diff;
  logic signed [SAMPLE_W+1:0]  pred_sum;
  logic signed [SAMPLE_W-1:0]  code_pred;
  logic signed [STEP_IDX_W:0]  idx_sum;
  logic [STEP_IDX_W-1:0]       code_idx;
  logic signed [SAMPLE_W-1:0]  pred_nxt;
  logic [STEP_IDX_W-1:0]       step_idx_nxt;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ch_r;
  assign out_tlast  = out_last_r;

  // channel select, folded to 0 in mono or beyond the channel count
  always_comb begin
    ch_eff = in_ch_r & stereo_r;
    if ({31'd0, ch_eff} >= MAX_CHANNELS) begin
      ch_eff = 1'b0;
    end
    ch_idx = CH_W'(ch_eff);
  end

  always_comb begin
    case (code_bits_r)
      3'd0, 3'd1, 3'd2: width = 3'd2;
      3'd3:             width = 3'd3;
      3'd4:             width = 3'd4;
      default:          width = 3'd5;
    endcase
  end

  // sign, magnitude, magnitude left-aligned to four bits, move table base
  always_comb begin
    case (width)
      3'd2: begin
        mag       = {4'd0, in_code_r[0]};
        sign      = in_code_r[1];
        mag_al    = {in_code_r[0], 3'd0};
        move_base = 5'd0;
      end
      3'd3: begin
        mag       = {3'd0, in_code_r[1:0]};
        sign      = in_code_r[2];
        mag_al    = {in_code_r[1:0], 2'd0};
        move_base = 5'd2;
      end
      3'd4: begin
        mag       = {2'd0, in_code_r[2:0]};
        sign      = in_code_r[3];
        mag_al    = {in_code_r[2:0], 1'b0};
        move_base = 5'd6;
      end
      default: begin
        mag       = {1'b0, in_code_r[3:0]};
        sign      = in_code_r[4];
        mag_al    = in_code_r[3:0];
        move_base = 5'd14;
      end
    endcase
  end

  assign si      = (step_idx_r[ch_idx] > MAX_STEP_IDX) ? MAX_STEP_IDX : step_idx_r[ch_idx];
  assign step    = STEP_TABLE[si];
  assign tail    = step >> (width - 3'd1);
  assign move_at = move_base + mag;

  assign diff = (mag_al[3] ? {2'd0, step}        : '0)
              + (mag_al[2] ? {3'd0, step[14:1]}  : '0)
              + (mag_al[1] ? {4'd0, step[14:2]}  : '0)
              + (mag_al[0] ? {5'd0, step[14:3]}  : '0)
              + {2'd0, tail};

  always_comb begin
    if (sign) begin
      pred_sum = {{2{pred_r[ch_idx][SAMPLE_W-1]}}, pred_r[ch_idx]} - $signed({1'b0, diff});
    end else begin
      pred_sum = {{2{pred_r[ch_idx][SAMPLE_W-1]}}, pred_r[ch_idx]} + $signed({1'b0, diff});
    end
    if (pred_sum < -18'sd32768) begin
      code_pred = 16'sh8000;
    end else if (pred_sum > 18'sd32767) begin
      code_pred = 16'sh7fff;
    end else begin
      code_pred = pred_sum[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    idx_sum = $signed({1'b0, si}) + STEP_IDX_W'(INDEX_MOVE[move_at]);
    if (idx_sum < 0) begin
      code_idx = '0;
    end else if (idx_sum > $signed({1'b0, MAX_STEP_IDX})) begin
      code_idx = MAX_STEP_IDX;
    end else begin
      code_idx = idx_sum[STEP_IDX_W-1:0];
    end
  end

  always_comb begin
    if (in_kind_r == KIND_HEADER) begin
      pred_nxt     = in_hp_r;
      step_idx_nxt = ({1'b0, in_hi_r} > MAX_STEP_IDX) ? MAX_STEP_IDX : {1'b0, in_hi_r};
    end else begin
      pred_nxt     = code_pred;
      step_idx_nxt = code_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_bits_r <= CODE_BITS_RESET;
      stereo_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CODE_BITS: code_bits_r <= cfg_data;
        REG_STEREO:    stereo_r    <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_kind_r <= in_tuser[0];
      in_ch_r   <= in_tuser[1];
      in_hp_r   <= in_tdata[15:0];
      in_hi_r   <= in_tdata[21:16];
      in_code_r <= in_tdata[26:22];
      in_last_r <= in_tlast;
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        pred_r[i]     <= '0;
        step_idx_r[i] <= '0;
      end
    end else if (advance && in_valid_r) begin
      pred_r[ch_idx]     <= pred_nxt;
      step_idx_r[ch_idx] <= step_idx_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_data_r <= pred_nxt;
      out_ch_r   <= ch_eff;
      out_last_r <= in_last_r;
    end
  end

  a_step_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
    step_idx_r[0] <= MAX_STEP_IDX)
    else $error("step index of channel 0 beyond table");

  a_out_drains : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tready && !in_valid_r |=> !out_tvalid)
    else $error("sample repeated after it was taken");

  a_header_echo : assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_valid_r && (in_kind_r == KIND_HEADER) |=> out_tdata == $past(in_hp_r))
    else $error("header predictor not returned as sample");

  a_stall_holds_input : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_code_r) && $stable(in_kind_r))
    else $error("pending request lost while output stalled");

endmodule
